[src/plcd_pkg.sv]
// plcd_pkg: types and constants shared by the deframer top level and its parser.
// No dependencies.
package plcd_pkg;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hFA;
  localparam logic [7:0] BUS_ID_BYTE   = 8'hFF;
  localparam logic [7:0] EXT_LEN_MARK  = 8'hFF;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd2048;

  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_BADSUM   = 3'd2;
  localparam logic [2:0] KIND_SYNCLOST = 3'd3;
  localparam logic [2:0] KIND_TOOLONG  = 3'd4;

  typedef enum logic [3:0] {
    PH_HUNT_PRE = 4'd0,
    PH_HUNT_BID = 4'd1,
    PH_SYNC_PRE = 4'd2,
    PH_SYNC_BID = 4'd3,
    PH_MSG_ID   = 4'd4,
    PH_LEN      = 4'd5,
    PH_EXT_HI   = 4'd6,
    PH_EXT_LO   = 4'd7,
    PH_PAYLOAD  = 4'd8,
    PH_CHECK    = 4'd9
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  message_id;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
  } result_t;

endpackage

[src/plcd_parse.sv]
// plcd_parse: frame parser state machine, one byte per enabled cycle.
// Depends on plcd_pkg.
module plcd_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       max_payload,
  output logic              res_vld,
  output plcd_pkg::result_t res
);
  import plcd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  sum_add;
  logic [15:0] len_chk;
  logic [15:0] cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT_PRE;
      sum_r   <= '0;
      id_r    <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign sum_add = sum_r + rx_byte;
  assign cnt_inc = cnt_r + 16'd1;
  assign len_chk = (phase_r == PH_LEN) ? {8'd0, rx_byte} : {len_r[15:8], rx_byte};

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    res_vld   = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_HUNT_BID: begin
        if (rx_byte == BUS_ID_BYTE) begin
          sum_nxt   = rx_byte;
          phase_nxt = PH_MSG_ID;
        end else if (rx_byte != PREAMBLE_BYTE) begin
          phase_nxt = PH_HUNT_PRE;
        end
      end
      PH_SYNC_PRE, PH_SYNC_BID: begin
        if (phase_r == PH_SYNC_PRE && rx_byte == PREAMBLE_BYTE) begin
          phase_nxt = PH_SYNC_BID;
        end else if (phase_r == PH_SYNC_BID && rx_byte == BUS_ID_BYTE) begin
          sum_nxt   = rx_byte;
          phase_nxt = PH_MSG_ID;
        end else begin
          res_vld   = 1'b1;
          res.kind  = KIND_SYNCLOST;
          phase_nxt = PH_HUNT_PRE;
        end
      end
      PH_MSG_ID: begin
        id_nxt    = rx_byte;
        sum_nxt   = sum_add;
        phase_nxt = PH_LEN;
      end
      PH_LEN, PH_EXT_LO: begin
        sum_nxt = sum_add;
        if (phase_r == PH_LEN && rx_byte == EXT_LEN_MARK) begin
          phase_nxt = PH_EXT_HI;
        end else begin
          len_nxt = len_chk;
          if (len_chk > max_payload) begin
            res_vld          = 1'b1;
            res.kind         = KIND_TOOLONG;
            res.message_id   = id_r;
            res.frame_length = len_chk;
            phase_nxt        = PH_HUNT_PRE;
          end else begin
            cnt_nxt   = '0;
            phase_nxt = (len_chk == 16'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
      end
      PH_EXT_HI: begin
        sum_nxt   = sum_add;
        len_nxt   = {rx_byte, 8'd0};
        phase_nxt = PH_EXT_LO;
      end
      PH_PAYLOAD: begin
        sum_nxt          = sum_add;
        res_vld          = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.message_id   = id_r;
        res.data_byte    = rx_byte;
        res.byte_index   = cnt_r;
        res.frame_length = len_r;
        cnt_nxt          = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        sum_nxt          = sum_add;
        res_vld          = 1'b1;
        res.message_id   = id_r;
        res.frame_length = len_r;
        if (sum_add == 8'd0) begin
          res.kind  = KIND_GOOD;
          phase_nxt = PH_SYNC_PRE;
        end else begin
          res.kind  = KIND_BADSUM;
          phase_nxt = PH_HUNT_PRE;
        end
      end
      default: begin
        phase_nxt = (rx_byte == PREAMBLE_BYTE) ? PH_HUNT_BID : PH_HUNT_PRE;
      end
    endcase
    if (!en) begin
      res_vld = 1'b0;
    end
  end

endmodule

[src/preamble_length_checksum_deframer_top.sv]
// Deframer for FA FF id length payload checksum frames: input register, parser and
// result register. Depends on plcd_pkg and plcd_parse.
//
// One received byte per request, one request per cycle sustained while the output is not stalled;
// each byte yields at most one result (payload byte, frame good, checksum bad, sync lost or
// frame too long). An accepted byte is held in the input register, the parser reads it and
// the result register captures the parser's output. While a result is held off, the input
// register keeps its byte and the input stalls once that register is full. The
// max_payload register may be written at any time the block is idle; cfg_ready is always high.
module preamble_length_checksum_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_message_id,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_byte_index,
  output logic [15:0] out_frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_payload
);
  import plcd_pkg::*;

  logic        s1_vld_r;
  logic [7:0]  s1_byte_r;
  logic [15:0] max_payload_r;
  logic        out_vld_r;
  result_t     out_r;
  logic        adv;
  logic        res_vld;
  result_t     res;

  assign cfg_ready = 1'b1;
  assign adv       = !out_vld_r || !out_stall;
  assign in_stall  = s1_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  plcd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (s1_vld_r && adv),
    .rx_byte     (s1_byte_r),
    .max_payload (max_payload_r),
    .res_vld     (res_vld),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_r.kind;
  assign out_message_id   = out_r.message_id;
  assign out_data_byte    = out_r.data_byte;
  assign out_byte_index   = out_r.byte_index;
  assign out_frame_length = out_r.frame_length;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with empty input register");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_vld) |=> out_vld_r)
    else $error("parser result not captured");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> !res_vld)
    else $error("result without an input byte");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.kind <= KIND_TOOLONG))
    else $error("result kind out of range");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.kind != KIND_PAYLOAD) |->
      (out_r.data_byte == 8'd0 && out_r.byte_index == 16'd0))
    else $error("non-payload result carries payload fields");

endmodule
